// ----- design/assert_macros.svh -----
// assertion helpers for the aes cbc core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/acbc_pkg.sv -----
// ----------------------------------------------------------------------------
// acbc_pkg
// shared types, constants and aes byte functions for the cbc byte stream core
// ----------------------------------------------------------------------------
`default_nettype none

package acbc_pkg;

  localparam int unsigned BlkBytes = 16;
  localparam int unsigned NRounds  = 10;

  typedef logic [3:0] cnt_t;
  typedef logic [127:0] blk_t;

  typedef enum logic [2:0] {
    REG_KEY_UPPER = 3'd0,
    REG_KEY_LOWER = 3'd1,
    REG_IV_UPPER  = 3'd2,
    REG_IV_LOWER  = 3'd3,
    REG_MODE      = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_GATHER,
    ST_START,
    ST_ROUND,
    ST_FINISH,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch gathered block, key and mode; do initial key add
    logic round;     // run one round
    logic finish;    // finalize cbc xor and chain update
    logic shift_out; // advance output byte
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_round;
    logic key_ready;  // round key for the selected mode is available
  } sts_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  // inverse sbox by table lookup
  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of a block sits at bits 127-8k
  function automatic logic [7:0] bget(input blk_t b, input int unsigned k);
    return b[127 - 8 * k -: 8];
  endfunction

  function automatic blk_t enc_round(input blk_t s, input logic last);
    blk_t o;
    logic [7:0] a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = sbox(bget(s, 4 * ((c + 0) % 4) + 0));
      a1 = sbox(bget(s, 4 * ((c + 1) % 4) + 1));
      a2 = sbox(bget(s, 4 * ((c + 2) % 4) + 2));
      a3 = sbox(bget(s, 4 * ((c + 3) % 4) + 3));
      if (last) begin
        o[127 - 32 * c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[127 - 32 * c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                                 a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                                 a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                                 xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
      end
    end
    return o;
  endfunction

  // inverse mix columns of one column
  function automatic logic [31:0] inv_mix(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int i = 0; i < 4; i++) begin
      a[i]  = w[31 - 8 * i -: 8];
      x2[i] = xt(a[i]);
      x4[i] = xt(x2[i]);
      x8[i] = xt(x4[i]);
      m9[i] = x8[i] ^ a[i];
      mb[i] = x8[i] ^ x2[i] ^ a[i];
      md[i] = x8[i] ^ x4[i] ^ a[i];
      me[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  // inverse shift rows and inverse sub bytes
  function automatic blk_t dec_sub(input blk_t s);
    blk_t o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (4 * c + r) -: 8] = inv_sbox(bget(s, 4 * ((c + 4 - r) % 4) + r));
      end
    end
    return o;
  endfunction

  function automatic blk_t inv_mix_blk(input blk_t s);
    blk_t o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      o[127 - 32 * c -: 32] = inv_mix(s[127 - 32 * c -: 32]);
    end
    return o;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // next round key forward
  function automatic blk_t key_fwd(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // previous round key; rc is that of the step being undone
  function automatic blk_t key_bwd(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w3 = k[31:0] ^ k[63:32];
    w2 = k[63:32] ^ k[95:64];
    w1 = k[95:64] ^ k[127:96];
    w0 = k[127:96] ^ sub_word({w3[23:0], w3[31:24]}) ^ {rc, 24'h0};
    return {w0, w1, w2, w3};
  endfunction

  // inverse of xtime for rcon stepping
  function automatic logic [7:0] xt_inv(input logic [7:0] a);
    return a[0] ? ({1'b1, a[7:1]} ^ 8'h0d) : {1'b0, a[7:1]};
  endfunction

endpackage

`default_nettype wire

// ----- design/acbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// acbc_ctrl
// sequencer for gather, ten aes rounds, cbc finish and byte emit
// ----------------------------------------------------------------------------
`default_nettype none

module acbc_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              blk_full,
  input  acbc_pkg::sts_t   sts,
  input  wire              out_take,
  input  wire              out_lastb,
  output logic             gather_en,
  output logic             out_vld,
  output acbc_pkg::cmd_t   cmd
);

  acbc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acbc_pkg::ST_GATHER;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    gather_en = 1'b0;
    out_vld   = 1'b0;
    unique case (state_r)
      acbc_pkg::ST_GATHER: begin
        gather_en = 1'b1;
        if (blk_full) state_nxt = acbc_pkg::ST_START;
      end
      acbc_pkg::ST_START: begin
        // decrypt waits here until the last round key walk is done
        if (sts.key_ready) begin
          cmd.load  = 1'b1;
          state_nxt = acbc_pkg::ST_ROUND;
        end
      end
      acbc_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        if (sts.last_round) state_nxt = acbc_pkg::ST_FINISH;
      end
      acbc_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = acbc_pkg::ST_EMIT;
      end
      acbc_pkg::ST_EMIT: begin
        out_vld       = 1'b1;
        cmd.shift_out = out_take;
        if (out_take && out_lastb) state_nxt = acbc_pkg::ST_GATHER;
      end
      default: state_nxt = acbc_pkg::ST_GATHER;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/acbc_dp.sv -----
// ----------------------------------------------------------------------------
// acbc_dp
// gather buffer, round state, key schedule, chaining block and output shifter
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module acbc_dp (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_we,
  input  wire  [2:0]       cfg_idx,
  input  wire  [63:0]      cfg_data,
  input  wire              byte_we,
  input  wire  [7:0]       byte_in,
  input  acbc_pkg::cmd_t   cmd,
  output acbc_pkg::sts_t   sts,
  output logic             blk_full,
  output logic [7:0]       out_byte,
  output logic             out_lastb
);

  logic [63:0]        key_up_r, key_lo_r;
  logic               mode_r;
  acbc_pkg::blk_t     chain_r;
  acbc_pkg::blk_t     gbuf_r;
  acbc_pkg::cnt_t     fill_r;
  acbc_pkg::blk_t     st_r, st_nxt;
  acbc_pkg::blk_t     rk_r, rk_nxt;
  logic [7:0]         rc_r, rc_nxt;
  logic [3:0]         rnd_r;
  logic               dec_r;
  acbc_pkg::blk_t     obuf_r;
  acbc_pkg::cnt_t     ocnt_r;
  acbc_pkg::blk_t     key_full;
  acbc_pkg::blk_t     dsub;
  logic               last_rnd;
  logic               key_rdy;
  acbc_pkg::blk_t     lk_r;
  logic [7:0]         lrc_r;
  logic [3:0]         lcnt_r;
  logic               lk_go_r;
  logic               lk_ok;

  assign key_full  = {key_up_r, key_lo_r};
  assign blk_full  = byte_we && (fill_r == 4'hf);
  assign out_byte  = obuf_r[127:120];
  assign out_lastb = (ocnt_r == 4'hf);
  assign last_rnd  = (rnd_r == 4'(acbc_pkg::NRounds));
  assign key_rdy   = !mode_r || lk_ok;
  assign sts       = '{last_round: last_rnd, key_ready: key_rdy};
  assign dsub = acbc_pkg::dec_sub(st_r) ^ rk_nxt;

  // config registers; iv writes load the chaining block directly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_up_r <= '0;
      key_lo_r <= '0;
      mode_r   <= 1'b0;
      chain_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          acbc_pkg::REG_KEY_UPPER: key_up_r <= cfg_data;
          acbc_pkg::REG_KEY_LOWER: key_lo_r <= cfg_data;
          acbc_pkg::REG_IV_UPPER:  chain_r[127:64] <= cfg_data;
          acbc_pkg::REG_IV_LOWER:  chain_r[63:0] <= cfg_data;
          acbc_pkg::REG_MODE:      mode_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.finish) begin
        chain_r <= dec_r ? gbuf_r : st_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (byte_we) begin
      fill_r <= fill_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_we) begin
      gbuf_r <= {gbuf_r[119:0], byte_in};
    end
  end

  // round engine: one round per cycle, key schedule walks forward or backward
  always_comb begin
    st_nxt = st_r;
    rk_nxt = rk_r;
    rc_nxt = rc_r;
    if (dec_r) begin
      rk_nxt = acbc_pkg::key_bwd(rk_r, rc_r);
      rc_nxt = acbc_pkg::xt_inv(rc_r);
      st_nxt = last_rnd ? dsub : acbc_pkg::inv_mix_blk(dsub);
    end else begin
      rk_nxt = acbc_pkg::key_fwd(rk_r, rc_r);
      rc_nxt = acbc_pkg::xt(rc_r);
      st_nxt = acbc_pkg::enc_round(st_r, last_rnd) ^ rk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0;
      dec_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        rnd_r <= 4'd1;
        dec_r <= mode_r;
      end else if (cmd.round && !last_rnd) begin
        rnd_r <= rnd_r + 4'd1;
      end
    end
  end

  // last round key for decrypt, walked from the key one step per cycle;
  // restarts the cycle after reset, a config write or a block finish
  assign lk_ok = (lcnt_r == 4'(acbc_pkg::NRounds)) && !lk_go_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_go_r <= 1'b1;
    end else begin
      lk_go_r <= cfg_we || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r <= '0;
    end else if (lk_go_r) begin
      lcnt_r <= '0;
    end else if (!lk_ok) begin
      lcnt_r <= lcnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (lk_go_r) begin
      lk_r  <= key_full;
      lrc_r <= 8'h01;
    end else if (!lk_ok) begin
      lk_r  <= acbc_pkg::key_fwd(lk_r, lrc_r);
      lrc_r <= acbc_pkg::xt(lrc_r);
    end
  end

  // block is complete in gbuf_r by the load cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (mode_r) begin
        st_r <= gbuf_r ^ lk_r;
        rk_r <= lk_r;
        rc_r <= 8'h36;
      end else begin
        st_r <= gbuf_r ^ chain_r ^ key_full;
        rk_r <= key_full;
        rc_r <= 8'h01;
      end
    end else if (cmd.round) begin
      st_r <= st_nxt;
      rk_r <= rk_nxt;
      rc_r <= rc_nxt;
    end else if (cmd.finish && dec_r) begin
      st_r <= st_r ^ chain_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      obuf_r <= dec_r ? (st_r ^ chain_r) : st_r;
    end else if (cmd.shift_out) begin
      obuf_r <= {obuf_r[119:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= '0;
    end else if (cmd.finish) begin
      ocnt_r <= '0;
    end else if (cmd.shift_out) begin
      ocnt_r <= ocnt_r + 4'd1;
    end
  end

  `ASSERT_NEXT(a_load_starts, cmd.load, rnd_r == 4'd1, "round counter not started")
  `ASSERT_ALWAYS(a_rnd_range, rnd_r <= 4'(acbc_pkg::NRounds), "round counter overrun")
  `ASSERT_NEXT(a_fill_wrap, blk_full, fill_r == 4'd0, "fill count did not wrap")

endmodule

`default_nettype wire

// ----- design/aes128_cbc_byte_stream_core.sv -----
// ----------------------------------------------------------------------------
// aes128_cbc_byte_stream_core
// aes-128 cbc engine on a byte stream with a 16 byte gather and emit
// ----------------------------------------------------------------------------
// usage:
//  - in_: one byte per beat, accepted when in_valid is high and in_stall low
//  - out_: 16 byte beats per completed block, out_block_last on the sixteenth
//  - cfg_: register writes (key, iv, mode) while the core is idle; iv writes
//    reload the chaining block at once
//  - input is taken one byte per cycle while gathering; on the sixteenth byte
//    the core runs a load step, ten rounds on a single round unit and a
//    finish step, then emits bytes, one per cycle unless stalled
//  - in_stall is high from the sixteenth byte until the last output beat
//    is taken
//  - decrypt uses the last round key, walked from the key a round step at a
//    time, anew after reset, any config write or block finish; the load waits
//    for the walk, so a config write late in a block delays the load
//  - synchronous reset clears fill count, key, iv and mode to zero
//  - out_stall holds the current output byte until it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_cbc_byte_stream_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_data_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_block_last,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [63:0] cfg_data
);

  acbc_pkg::cmd_t cmd;
  acbc_pkg::sts_t sts;
  logic gather_en, blk_full, out_lastb, byte_we;

  assign in_stall  = !gather_en;
  assign cfg_ready = 1'b1;
  assign byte_we   = in_valid && gather_en;
  assign out_block_last = out_lastb;

  acbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .blk_full  (blk_full),
    .sts       (sts),
    .out_take  (out_valid && !out_stall),
    .out_lastb (out_lastb),
    .gather_en (gather_en),
    .out_vld   (out_valid),
    .cmd       (cmd)
  );

  acbc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_data  (cfg_data),
    .byte_we   (byte_we),
    .byte_in   (in_data_byte),
    .cmd       (cmd),
    .sts       (sts),
    .blk_full  (blk_full),
    .out_byte  (out_out_byte),
    .out_lastb (out_lastb)
  );

endmodule

`default_nettype wire

// ----- sim/aes128_cbc_byte_stream_core_test.sv -----
// ----------------------------------------------------------------------------
// aes128_cbc_byte_stream_core_test
// drives bytes through the cbc core in both directions under several keys
// and iv values, predicts every emitted byte and checks it in order
// ----------------------------------------------------------------------------
`default_nettype none

package acbc_test_pkg;

  typedef struct {
    logic [7:0] byte_val;
    logic       last;
  } cbc_beat_t;

  localparam int unsigned BlockBytes = 16;

  function automatic logic [7:0] times2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = times2(a);
    end
    return r;
  endfunction

  function automatic logic [7:0] fwd_sub(input logic [7:0] v);
    logic [7:0] r, x;
    logic [7:0] inv;
    // multiplicative inverse by brute force, then the affine map
    inv = 8'h00;
    for (int i = 1; i < 256; i++) begin
      if (gf_mul(v, i[7:0]) == 8'h01) inv = i[7:0];
    end
    x = inv;
    r = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]} ^ {x[3:0], x[7:4]} ^ 8'h63;
    return r;
  endfunction

  class cbc_scoreboard;
    logic [7:0] sub_tab [256];
    logic [7:0] inv_tab [256];
    logic [63:0] key_hi, key_lo;
    logic        decrypting;
    logic [7:0]  gathered [16];
    logic [7:0]  chain [16];
    int unsigned fill;
    cbc_beat_t   pending [$];
    int unsigned errors;

    function new();
      for (int i = 0; i < 256; i++) begin
        sub_tab[i] = fwd_sub(i[7:0]);
        inv_tab[sub_tab[i]] = i[7:0];
      end
      key_hi = '0; key_lo = '0; decrypting = 1'b0; fill = 0;
      errors = 0;
      for (int i = 0; i < 16; i++) chain[i] = 8'h00;
    endfunction

    function void write_reg(input acbc_pkg::reg_idx_t idx, input logic [63:0] val);
      case (idx)
        acbc_pkg::REG_KEY_UPPER: key_hi = val;
        acbc_pkg::REG_KEY_LOWER: key_lo = val;
        acbc_pkg::REG_IV_UPPER: begin
          for (int i = 0; i < 8; i++) chain[i] = val[63 - 8 * i -: 8];
        end
        acbc_pkg::REG_IV_LOWER: begin
          for (int i = 0; i < 8; i++) chain[8 + i] = val[63 - 8 * i -: 8];
        end
        acbc_pkg::REG_MODE: decrypting = val[0];
        default: ;
      endcase
    endfunction

    function void make_schedule(output logic [7:0] rk [176]);
      logic [7:0] t [4];
      logic [7:0] rc, tmp;
      rc = 8'h01;
      for (int i = 0; i < 8; i++) begin
        rk[i] = key_hi[63 - 8 * i -: 8];
        rk[8 + i] = key_lo[63 - 8 * i -: 8];
      end
      for (int i = 16; i < 176; i += 4) begin
        for (int j = 0; j < 4; j++) t[j] = rk[i - 4 + j];
        if (i % 16 == 0) begin
          tmp = t[0];
          t[0] = sub_tab[t[1]] ^ rc;
          t[1] = sub_tab[t[2]];
          t[2] = sub_tab[t[3]];
          t[3] = sub_tab[tmp];
          rc = times2(rc);
        end
        for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ t[j];
      end
    endfunction

    function void shift(inout logic [7:0] s [16], input bit fwd);
      logic [7:0] t [16];
      int src;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          src = fwd ? ((c + r) % 4) : ((c + 4 - r) % 4);
          t[4 * c + r] = s[4 * src + r];
        end
      end
      s = t;
    endfunction

    function void mix(inout logic [7:0] s [16], input bit fwd);
      logic [7:0] m0, m1, m2, m3, a0, a1, a2, a3;
      m0 = fwd ? 8'd2 : 8'd14; m1 = fwd ? 8'd3 : 8'd11;
      m2 = fwd ? 8'd1 : 8'd13; m3 = fwd ? 8'd1 : 8'd9;
      for (int c = 0; c < 4; c++) begin
        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
        s[4*c]   = gf_mul(a0, m0) ^ gf_mul(a1, m1) ^ gf_mul(a2, m2) ^ gf_mul(a3, m3);
        s[4*c+1] = gf_mul(a0, m3) ^ gf_mul(a1, m0) ^ gf_mul(a2, m1) ^ gf_mul(a3, m2);
        s[4*c+2] = gf_mul(a0, m2) ^ gf_mul(a1, m3) ^ gf_mul(a2, m0) ^ gf_mul(a3, m1);
        s[4*c+3] = gf_mul(a0, m1) ^ gf_mul(a1, m2) ^ gf_mul(a2, m3) ^ gf_mul(a3, m0);
      end
    endfunction

    function void note_input(input logic [7:0] b);
      logic [7:0] rk [176];
      logic [7:0] s [16];
      cbc_beat_t beat;
      gathered[fill] = b;
      fill++;
      if (fill < BlockBytes) return;
      fill = 0;
      make_schedule(rk);
      if (decrypting) begin
        s = gathered;
        for (int i = 0; i < 16; i++) s[i] ^= rk[160 + i];
        for (int rnd = 9; rnd >= 0; rnd--) begin
          shift(s, 1'b0);
          for (int i = 0; i < 16; i++) s[i] = inv_tab[s[i]];
          for (int i = 0; i < 16; i++) s[i] ^= rk[16 * rnd + i];
          if (rnd != 0) mix(s, 1'b0);
        end
        for (int i = 0; i < 16; i++) s[i] ^= chain[i];
        chain = gathered;
      end else begin
        for (int i = 0; i < 16; i++) s[i] = gathered[i] ^ chain[i] ^ rk[i];
        for (int rnd = 1; rnd <= 10; rnd++) begin
          for (int i = 0; i < 16; i++) s[i] = sub_tab[s[i]];
          shift(s, 1'b1);
          if (rnd != 10) mix(s, 1'b1);
          for (int i = 0; i < 16; i++) s[i] ^= rk[16 * rnd + i];
        end
        chain = s;
      end
      for (int i = 0; i < 16; i++) begin
        beat.byte_val = s[i];
        beat.last = (i == 15);
        pending.push_back(beat);
      end
    endfunction

    task report(input string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_output(input logic [7:0] b, input logic last);
      cbc_beat_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat byte %02h last %0b", b, last));
        return;
      end
      e = pending.pop_front();
      if (b !== e.byte_val) report($sformatf("byte got %02h want %02h", b, e.byte_val));
      if (last !== e.last) report($sformatf("last got %0b want %0b", last, e.last));
    endtask
  endclass

endpackage

module aes128_cbc_byte_stream_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_out_byte;
  logic        out_block_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  acbc_test_pkg::cbc_scoreboard board;
  bit          hold_off;

  aes128_cbc_byte_stream_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_out_byte(out_out_byte),
    .out_block_last(out_block_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    in_valid = 1'b0; in_data_byte = '0; out_stall = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    rst_n = 1'b0;
    board = new();
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= 3'd4) board.write_reg(acbc_pkg::reg_idx_t'(idx), val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one byte beat, gap drawn before it
  task automatic send_byte(input logic [7:0] b, input bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(18, 0) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    board.note_input(b);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // drops in_valid, waits for every expected beat, then lets the core settle
  task automatic drain();
    release_input();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_block(input bit gaps);
    for (int i = 0; i < 16; i++) send_byte(8'($urandom_range(255, 0)), gaps);
  endtask

  task automatic set_all(input logic [63:0] k0, input logic [63:0] k1,
                         input logic [63:0] v0, input logic [63:0] v1, input bit dec);
    write_reg(acbc_pkg::REG_KEY_UPPER, k0);
    write_reg(acbc_pkg::REG_KEY_LOWER, k1);
    write_reg(acbc_pkg::REG_IV_UPPER, v0);
    write_reg(acbc_pkg::REG_IV_LOWER, v1);
    write_reg(acbc_pkg::REG_MODE, {63'd0, dec});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // output side: random stalls plus one long hold-off
  initial begin
    int unsigned wait_n;
    @(posedge rst_n);
    forever begin
      wait_n = $urandom_range(1, 0) ? $urandom_range(18, 0) : 0;
      repeat (wait_n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      while (hold_off) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_output(out_out_byte, out_block_last);
  end

  initial begin
    hold_off = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset state: zero key, zero iv, encrypt
    for (int i = 0; i < 16; i++) send_byte(8'h00, 1'b0);
    drain();
    set_all('1, '1, '1, '1, 1'b1);
    for (int i = 0; i < 16; i++) send_byte(8'hff, 1'b0);
    drain();
    // wide mode value and two unknown indices
    write_reg(acbc_pkg::REG_MODE, 64'hffff_ffff_ffff_fffe);
    write_reg(3'd5, rand64());
    write_reg(3'd7, rand64());
    for (int i = 0; i < 5; i++) send_byte(8'h80 >> i, 1'b0);
    drain();
    // iv write mid-block, mode flip mid-block
    write_reg(acbc_pkg::REG_IV_UPPER, 64'h0123_4567_89ab_cdef);
    write_reg(acbc_pkg::REG_MODE, 64'd1);
    for (int i = 0; i < 11; i++) send_byte(8'h01 << (i % 8), 1'b0);
    drain();

    // long hold-off on the output while the input keeps offering
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_block(1'b0);
        send_block(1'b0);
      end
    join
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_all(rand64(), rand64(), rand64(), rand64(), 1'b0);
        1: set_all(rand64(), rand64(), rand64(), rand64(), 1'b1);
        2: set_all('0, '1, '1, '0, 1'($urandom_range(1, 0)));
        3: begin
          write_reg(acbc_pkg::REG_KEY_UPPER, rand64());
          write_reg(acbc_pkg::REG_MODE, {63'd0, 1'b0});
        end
        4: write_reg(acbc_pkg::REG_IV_LOWER, rand64());
        default: set_all(rand64(), rand64(), rand64(), rand64(), 1'($urandom_range(1, 0)));
      endcase
      send_block(phase % 2 == 0);
      drain();
    end
    if (board.errors == 0) begin
      $display("aes128_cbc_byte_stream_core verification clean");
    end else begin
      $display("aes128_cbc_byte_stream_core verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("aes128_cbc_byte_stream_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire
